// ===== hw/rtl/bf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3_pkg: shared types and constants of the 3x3 box filter
// Holds the beat structs of both channels, the per-item position tag and the
// register indexes and arithmetic constants of the filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

  // Width of the frame size registers and of the position counters.
  localparam int DIM_W = 10;
  // Pixel width.
  localparam int PIX_W = 8;
  // Nine 8-bit terms need 12 bits.
  localparam int SUM_W = 12;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Smallest frame dimension that the filter works with.
  localparam logic [DIM_W-1:0] MIN_DIM   = 10'd3;
  localparam logic [DIM_W-1:0] RESET_DIM = 10'd512;

  // Division by nine as a multiply by 7282 / 2^16; exact for sums up to 2295.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

  // Input beat.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             is_pad;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic             frame_last;
  } out_beat_t;

  // What one accepted item means for the result side: whether it produces a
  // result, which window borders fall outside the image and whether it ends
  // the frame.
  typedef struct packed {
    logic emit;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } tag_t;

endpackage

// ===== hw/rtl/bf3_pos_ctrl.sv =====
// ----------------------------------------------------------------------------
// bf3_pos_ctrl: frame size registers and raster position counters
// Tracks the column and row of the incoming pixel and of the window center,
// and tags every accepted item with its result flags and border masks.
// ----------------------------------------------------------------------------
module bf3_pos_ctrl
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  output logic [DIM_W-1:0]      col,
  output tag_t                  tag
);

  // Largest width the line buffers and the counters can both serve.
  localparam int WMAX = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
  localparam logic [DIM_W-1:0] WMAX_DIM  = DIM_W'(WMAX);
  localparam logic [DIM_W-1:0] WIDTH_RST = (RESET_DIM > WMAX_DIM) ? WMAX_DIM : RESET_DIM;

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [DIM_W-1:0] in_col_r, in_col_nxt;
  logic [DIM_W-1:0] in_row_r, in_row_nxt;
  logic [DIM_W-1:0] out_col_r, out_col_nxt;
  logic [DIM_W-1:0] out_row_r, out_row_nxt;

  logic [DIM_W:0]   out_col_p1;
  logic [DIM_W:0]   out_row_p1;
  logic [DIM_W-1:0] out_col_wrap;

  assign col = in_col_r;

  // Tag of the item at the input: result present, borders, end of frame.
  always_comb begin
    out_col_p1   = {1'b0, out_col_r} + 1'b1;
    out_row_p1   = {1'b0, out_row_r} + 1'b1;
    out_col_wrap = out_col_p1[DIM_W-1:0];
    tag.emit   = (in_row_r >= 10'd2) || (in_row_r == 10'd1 && in_col_r != '0);
    tag.top    = (out_row_r == '0);
    tag.bottom = (out_row_p1 >= {1'b0, height_r});
    tag.left   = (out_col_r == '0);
    tag.right  = (out_col_p1 >= {1'b0, width_r});
    tag.last   = tag.bottom && tag.right;
  end

  // Next values of the registers and counters.
  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      // A register write starts a new frame.
      case (cfg_idx)
        REG_IMAGE_WIDTH: begin
          if (cfg_data < MIN_DIM) begin
            width_nxt = MIN_DIM;
          end else if (cfg_data > WMAX_DIM) begin
            width_nxt = WMAX_DIM;
          end else begin
            width_nxt = cfg_data;
          end
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt  = (cfg_data < MIN_DIM) ? MIN_DIM : cfg_data;
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      // Input position moves one pixel in raster order.
      if (in_col_r + 1'b1 >= width_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (tag.emit) begin
        if (tag.last) begin
          // The frame's final result returns every counter to the origin.
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_wrap >= width_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_wrap;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RST;
      height_r  <= RESET_DIM;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

// ===== hw/rtl/bf3_line_buf.sv =====
// ----------------------------------------------------------------------------
// bf3_line_buf: two line buffers holding the previous two rows
// Each accepted pixel reads the upper and middle entries of its column and
// writes itself into the middle buffer. The old middle entry moves to the
// upper buffer one beat later, with a bypass when the next beat reads the
// same column.
// ----------------------------------------------------------------------------
module bf3_line_buf
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [DIM_W-1:0] col,
  input  logic [PIX_W-1:0] px,
  output logic [PIX_W-1:0] up,
  output logic [PIX_W-1:0] mid
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0]  upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_mem [MAX_WIDTH];

  logic [ADDR_W-1:0] addr;
  logic [PIX_W-1:0]  up_rd_r;
  logic [PIX_W-1:0]  mid_rd_r;
  logic [PIX_W-1:0]  fwd_data_r;
  logic              fwd_r;
  logic              pend_v_r;
  logic [ADDR_W-1:0] pend_addr_r;

  assign addr = ADDR_W'(col);

  // Memory port: read both rows, store the new pixel, retire the pending
  // upper write of the previous beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r          <= upper_mem[addr];
      mid_rd_r         <= middle_mem[addr];
      middle_mem[addr] <= px;
      if (pend_v_r) begin
        upper_mem[pend_addr_r] <= mid_rd_r;
      end
      fwd_data_r  <= mid_rd_r;
      pend_addr_r <= addr;
    end
  end

  // Pending-write control and bypass select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else if (accept) begin
      pend_v_r <= 1'b1;
      fwd_r    <= pend_v_r && (pend_addr_r == addr);
    end
  end

  assign up  = fwd_r ? fwd_data_r : up_rd_r;
  assign mid = mid_rd_r;

endmodule

// ===== hw/rtl/bf3_win_sum.sv =====
// ----------------------------------------------------------------------------
// bf3_win_sum: 3x3 shift window and masked window sum
// Shifts in one new column per item and registers the sum of the window
// positions that lie inside the image.
// ----------------------------------------------------------------------------
module bf3_win_sum
  import bf3_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  logic [PIX_W-1:0] up,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] px,
  input  logic             sum_en,
  input  tag_t             mask,
  output logic [SUM_W-1:0] sum
);

  // Row 0 is the upper line, row 2 the newest; column 2 is the newest.
  logic [PIX_W-1:0] win_r [3][3];
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Window shift.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up;
      win_r[1][2] <= mid;
      win_r[2][2] <= px;
    end
  end

  // Sum of the window positions inside the image.
  always_comb begin
    sum_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 0 && mask.top) || (r == 2 && mask.bottom) ||
              (c == 0 && mask.left) || (c == 2 && mask.right))) begin
          sum_nxt = sum_nxt + SUM_W'(win_r[r][c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// ===== hw/rtl/box_filter_3x3_zero_pad.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_zero_pad: streaming 3x3 mean filter with zero padding
// Takes an 8-bit grayscale frame in raster order and returns the truncated
// mean of each 3x3 neighborhood, counting pixels outside the image as zero.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_beat_t  (pixel, is_pad)
//   out_     output     out_valid / out_stall out_beat_t (mean_value, frame_last)
//   cfg_     input      cfg_we                cfg_idx, cfg_data
//
// One beat is accepted per clock while in_stall is low. The beat that produces
// a result passes through the line-buffer read, window, sum and divide
// registers. Each stage holds under a stall only when the stage after it is
// full, so the input keeps moving while the result waits, until every stage is full.
// Reset clears the counters, the stage valids and the window and sets both
// size registers to 512, the width capped at the largest supported width;
// the line buffers are not initialized.
// ----------------------------------------------------------------------------
module box_filter_3x3_zero_pad
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic             accept;
  logic [DIM_W-1:0] col;
  tag_t             tag_in;
  logic [PIX_W-1:0] px_in;
  logic [PIX_W-1:0] up;
  logic [PIX_W-1:0] mid;
  logic [SUM_W-1:0] sum;
  logic [PROD_W-1:0] prod;

  // Stage registers: line-buffer read, window, sum, result.
  logic             v1_r;
  tag_t             tag1_r;
  logic [PIX_W-1:0] px1_r;
  logic             v2_r;
  tag_t             tag2_r;
  logic             v3_r;
  logic             last3_r;
  logic             out_valid_r;
  out_beat_t        out_data_r;

  logic rdy_out, rdy3, rdy2, rdy1;

  // Ready chain; an empty stage absorbs a beat even while the output waits.
  assign rdy_out = !out_valid_r || !out_stall;
  assign rdy3    = !v3_r || rdy_out;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;

  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  // A pad beat enters as a zero pixel.
  assign px_in = in_data.is_pad ? '0 : in_data.pixel;

  bf3_pos_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .accept   (accept),
    .col      (col),
    .tag      (tag_in)
  );

  bf3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .col    (col),
    .px     (px_in),
    .up     (up),
    .mid    (mid)
  );

  bf3_win_sum u_win_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (v1_r && rdy2),
    .up       (up),
    .mid      (mid),
    .px       (px1_r),
    .sum_en   (rdy3),
    .mask     (tag2_r),
    .sum      (sum)
  );

  // Stage valids; every beat shifts the window, only emitting beats go on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= accept;
      end
      if (rdy2) begin
        v2_r <= v1_r && tag1_r.emit;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (accept) begin
      tag1_r <= tag_in;
      px1_r  <= px_in;
    end
    if (rdy2) begin
      tag2_r <= tag1_r;
    end
    if (rdy3) begin
      last3_r <= tag2_r.last;
    end
    if (rdy_out) begin
      out_data_r.mean_value <= prod[RECIP_SHIFT +: PIX_W];
      out_data_r.frame_last <= last3_r;
    end
  end

  // Division by nine through the reciprocal.
  assign prod = PROD_W'(sum) * PROD_W'(RECIP_9);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
